>>> rtl/vml_pkg.sv
// ---------------------------------------------------------------------------
// vml_pkg: shared types and constants of the vector magnitude limiter
// Component widths, cell payload structs and a magnitude helper.
// ---------------------------------------------------------------------------
`default_nettype none

package vml_pkg;

    localparam int CW   = 16;            // component width
    localparam int LW   = CW - 1;        // limit width
    localparam int SQW  = 2 * CW;        // sum of squares width
    localparam int NW   = CW;            // norm width
    localparam int REMW = CW + 2;        // square root remainder width
    localparam int PW   = 2 * CW - 2;    // component times limit width
    localparam int QW   = LW;            // quotient width

    localparam logic [LW-1:0] LIMIT_RESET = '1;

    // word carried along the square root cells
    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_sq_side;

    // working state of one square root cell
    typedef struct packed {
        logic [SQW-1:0]  rad;
        logic [REMW-1:0] rem;
        logic [NW-1:0]   root;
    } t_sq;

    // word carried along the divider cells
    typedef struct packed {
        logic                 valid;
        logic                 limited;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [NW-1:0]        norm;
    } t_dv_side;

    // working state of one restoring division
    typedef struct packed {
        logic [NW-1:0] r;
        logic [QW-1:0] low;
        logic [QW-1:0] q;
    } t_dv;

    // absolute value of a signed component, returned unsigned so the most
    // negative value fits
    function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
        logic [CW-1:0] u;
        u = v;
        return v[CW-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

`default_nettype wire

>>> rtl/vml_sqrt_cell.sv
// ---------------------------------------------------------------------------
// vml_sqrt_cell: one step of the integer square root
// Retires two radicand bits and produces one root bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module vml_sqrt_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire vml_pkg::t_sq_side i_side,
    input  wire vml_pkg::t_sq    i_sq,
    output vml_pkg::t_sq_side    o_side,
    output vml_pkg::t_sq         o_sq
);

    vml_pkg::t_sq_side r_side;
    vml_pkg::t_sq      r_sq;
    vml_pkg::t_sq      n_sq;

    logic [vml_pkg::REMW+1:0] cur;
    logic [vml_pkg::REMW+1:0] trial;
    logic [vml_pkg::REMW+1:0] diff;

    // bring down two bits and try the next root bit
    always_comb begin
        cur   = {i_sq.rem, i_sq.rad[vml_pkg::SQW-1 -: 2]};
        trial = {{(vml_pkg::REMW-vml_pkg::NW){1'b0}}, i_sq.root, 2'b01};
        diff  = cur - trial;
        n_sq.rad = {i_sq.rad[vml_pkg::SQW-3:0], 2'b00};
        if (cur >= trial) begin
            n_sq.rem  = diff[vml_pkg::REMW-1:0];
            n_sq.root = {i_sq.root[vml_pkg::NW-2:0], 1'b1};
        end else begin
            n_sq.rem  = cur[vml_pkg::REMW-1:0];
            n_sq.root = {i_sq.root[vml_pkg::NW-2:0], 1'b0};
        end
    end

    // advance the word to the next cell
    always_ff @(posedge i_clk) begin
        r_sq   <= n_sq;
        r_side <= i_side;
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end
    end

    assign o_side = r_side;
    assign o_sq   = r_sq;

endmodule

`default_nettype wire

>>> rtl/vml_div_cell.sv
// ---------------------------------------------------------------------------
// vml_div_cell: one step of the two restoring divisions
// Produces one quotient bit of each scaled component per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module vml_div_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire vml_pkg::t_dv_side i_side,
    input  wire vml_pkg::t_dv    i_dx,
    input  wire vml_pkg::t_dv    i_dy,
    output vml_pkg::t_dv_side    o_side,
    output vml_pkg::t_dv         o_dx,
    output vml_pkg::t_dv         o_dy
);

    vml_pkg::t_dv_side r_side;
    vml_pkg::t_dv      r_dx;
    vml_pkg::t_dv      r_dy;

    function automatic vml_pkg::t_dv step(input vml_pkg::t_dv d,
                                          input logic [vml_pkg::NW-1:0] den);
        logic [vml_pkg::NW:0] cur;
        logic [vml_pkg::NW:0] diff;
        vml_pkg::t_dv         o;
        cur   = {d.r, d.low[vml_pkg::QW-1]};
        diff  = cur - {1'b0, den};
        o.low = {d.low[vml_pkg::QW-2:0], 1'b0};
        if (cur >= {1'b0, den}) begin
            o.r = diff[vml_pkg::NW-1:0];
            o.q = {d.q[vml_pkg::QW-2:0], 1'b1};
        end else begin
            o.r = cur[vml_pkg::NW-1:0];
            o.q = {d.q[vml_pkg::QW-2:0], 1'b0};
        end
        return o;
    endfunction

    // subtract the norm where it fits and pass on
    always_ff @(posedge i_clk) begin
        r_dx   <= step(i_dx, i_side.norm);
        r_dy   <= step(i_dy, i_side.norm);
        r_side <= i_side;
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end
    end

    assign o_side = r_side;
    assign o_dx   = r_dx;
    assign o_dy   = r_dy;

endmodule

`default_nettype wire

>>> rtl/vector_magnitude_limiter.sv
// ---------------------------------------------------------------------------
// vector_magnitude_limiter: circle limitation of a 2-D vector
// Scales (x, y) onto the configured radius when its length exceeds it.
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  command  | i_start / o_busy       | i_x_in, i_y_in
//  result   | o_valid (strobe)       | o_x_out, o_y_out, o_was_limited
//  config   | i_cfg_valid/o_cfg_ready| i_cfg_data (max_magnitude)
//
//  One word is taken every cycle; o_busy stays low.
//  The pipeline holds 2 registers for magnitude and squares, 16 square root
//  cells, 1 for compare and product, 15 divider cells, 1 output register.
//  Reset clears the valid bits of every cell and sets the limit to all ones.
//  The receiver cannot stall; results are strobed for one cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_magnitude_limiter (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    output logic                             o_busy,
    input  wire signed [vml_pkg::CW-1:0]     i_x_in,
    input  wire signed [vml_pkg::CW-1:0]     i_y_in,
    output logic                             o_valid,
    output logic signed [vml_pkg::CW-1:0]    o_x_out,
    output logic signed [vml_pkg::CW-1:0]    o_y_out,
    output logic                             o_was_limited,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [vml_pkg::LW-1:0]            i_cfg_data
);

    localparam int NSQ = vml_pkg::NW;
    localparam int NDV = vml_pkg::QW;

    logic [vml_pkg::LW-1:0] r_lim;

    // magnitude and squaring stages
    logic                         r_v0, r_v1;
    logic signed [vml_pkg::CW-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [vml_pkg::CW-1:0]       r_ax, r_ay;
    logic [vml_pkg::SQW-1:0]      r_sqx, r_sqy;

    vml_pkg::t_sq_side sq_side [NSQ+1];
    vml_pkg::t_sq      sq      [NSQ+1];

    vml_pkg::t_dv_side r_dside;
    vml_pkg::t_dv      r_dx0, r_dy0;
    vml_pkg::t_dv_side dv_side [NDV+1];
    vml_pkg::t_dv      dv_x    [NDV+1];
    vml_pkg::t_dv      dv_y    [NDV+1];

    logic [vml_pkg::CW-1:0]   mx, my;
    logic [vml_pkg::PW:0]     px, py;
    logic [vml_pkg::NW-1:0]   norm;
    logic [vml_pkg::CW-1:0]   qx, qy;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // hold the limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= vml_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_lim <= i_cfg_data;
        end
    end

    // take the word, form magnitudes and squares
    always_ff @(posedge i_clk) begin
        r_x0  <= i_x_in;
        r_y0  <= i_y_in;
        r_ax  <= vml_pkg::mag(i_x_in);
        r_ay  <= vml_pkg::mag(i_y_in);
        r_x1  <= r_x0;
        r_y1  <= r_y0;
        r_sqx <= r_ax * r_ax;
        r_sqy <= r_ay * r_ay;
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= i_start && !o_busy;
            r_v1 <= r_v0;
        end
    end

    // feed the square root chain
    assign sq_side[0] = '{valid: r_v1, x: r_x1, y: r_y1};
    assign sq[0]      = '{rad: r_sqx + r_sqy, rem: '0, root: '0};

    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        vml_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_side  (sq_side[g]),
            .i_sq    (sq[g]),
            .o_side  (sq_side[g+1]),
            .o_sq    (sq[g+1])
        );
    end

    // compare the norm and form the dividends
    assign norm = sq[NSQ].root;
    assign mx   = vml_pkg::mag(sq_side[NSQ].x);
    assign my   = vml_pkg::mag(sq_side[NSQ].y);
    assign px   = mx * r_lim;
    assign py   = my * r_lim;

    always_ff @(posedge i_clk) begin
        r_dside.limited <= norm > {1'b0, r_lim};
        r_dside.x       <= sq_side[NSQ].x;
        r_dside.y       <= sq_side[NSQ].y;
        r_dside.norm    <= norm;
        r_dx0 <= '{r: {1'b0, px[vml_pkg::PW-1:vml_pkg::QW]},
                   low: px[vml_pkg::QW-1:0], q: '0};
        r_dy0 <= '{r: {1'b0, py[vml_pkg::PW-1:vml_pkg::QW]},
                   low: py[vml_pkg::QW-1:0], q: '0};
        if (!i_rst_n) begin
            r_dside.valid <= 1'b0;
        end else begin
            r_dside.valid <= sq_side[NSQ].valid;
        end
    end

    assign dv_side[0] = r_dside;
    assign dv_x[0]    = r_dx0;
    assign dv_y[0]    = r_dy0;

    for (genvar g = 0; g < NDV; g++) begin : g_div
        vml_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_side  (dv_side[g]),
            .i_dx    (dv_x[g]),
            .i_dy    (dv_y[g]),
            .o_side  (dv_side[g+1]),
            .o_dx    (dv_x[g+1]),
            .o_dy    (dv_y[g+1])
        );
    end

    // restore the signs and select the result
    assign qx = {1'b0, dv_x[NDV].q};
    assign qy = {1'b0, dv_y[NDV].q};

    always_ff @(posedge i_clk) begin
        if (dv_side[NDV].limited) begin
            o_x_out <= dv_side[NDV].x[vml_pkg::CW-1] ? -qx : qx;
            o_y_out <= dv_side[NDV].y[vml_pkg::CW-1] ? -qy : qy;
        end else begin
            o_x_out <= dv_side[NDV].x;
            o_y_out <= dv_side[NDV].y;
        end
        o_was_limited <= dv_side[NDV].limited;
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= dv_side[NDV].valid;
        end
    end

    // a scaled vector never leaves the circle per component
    a_x_within: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_limited |-> vml_pkg::mag(o_x_out) <= {1'b0, r_lim})
        else $error("scaled x exceeds limit");

    a_y_within: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_limited |-> vml_pkg::mag(o_y_out) <= {1'b0, r_lim})
        else $error("scaled y exceeds limit");

    a_lim_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cfg_valid && o_cfg_ready) |=> $stable(r_lim))
        else $error("limit changed without a write");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

endmodule

`default_nettype wire

>>> dv/vector_magnitude_limiter_tb.sv
// ---------------------------------------------------------------------------
// vector_magnitude_limiter_tb: self-checking bench of the circle limiter
// Drives vectors under random gaps, predicts each limited word and compares
// every strobed result against the oldest prediction, over several limits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_magnitude_limiter_tb;

    localparam int CW        = vml_pkg::CW;
    localparam int LW        = vml_pkg::LW;
    localparam int LATENCY   = 35;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_vec;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 limited;
    } t_lim;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic signed [CW-1:0] i_x_in;
    logic signed [CW-1:0] i_y_in;
    logic                 o_valid;
    logic signed [CW-1:0] o_x_out;
    logic signed [CW-1:0] o_y_out;
    logic                 o_was_limited;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [LW-1:0]        i_cfg_data;

    t_vec         vec_q[$];
    t_lim         limited_q[$];
    logic [LW-1:0] radius;
    logic [LW-1:0] cfg_req;
    logic         cfg_pending;
    logic         hold_off;
    logic         calm;
    int           gap;
    int           fails;
    int           cycle;

    vector_magnitude_limiter uut (.*);

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] floor_sqrt(input logic [31:0] s);
        logic [31:0] r;
        logic [31:0] b;
        r = 0;
        b = 32'h4000_0000;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_lim limit_vector(input t_vec v, input logic [LW-1:0] lim);
        logic [16:0] ax;
        logic [16:0] ay;
        logic [31:0] nrm;
        logic [47:0] qx;
        logic [47:0] qy;
        t_lim        res;
        ax  = v.x < 0 ? -$signed({v.x[CW-1], v.x}) : {1'b0, v.x};
        ay  = v.y < 0 ? -$signed({v.y[CW-1], v.y}) : {1'b0, v.y};
        nrm = floor_sqrt(ax * ax + ay * ay);
        if (nrm > lim) begin
            qx = (48'(ax) * lim) / nrm;
            qy = (48'(ay) * lim) / nrm;
            res.x = v.x < 0 ? -qx[CW-1:0] : qx[CW-1:0];
            res.y = v.y < 0 ? -qy[CW-1:0] : qy[CW-1:0];
            res.limited = 1'b1;
        end else begin
            res.x = v.x;
            res.y = v.y;
            res.limited = 1'b0;
        end
        return res;
    endfunction

    // driver: present a word, advance on acceptance, idle in bursts
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (!i_rst_n) begin
            i_start <= 1'b0;
            gap     <= 0;
        end else if (i_start && o_busy) begin
            i_start <= 1'b1;
        end else begin
            if (i_start)
                limited_q.push_back(limit_vector('{i_x_in, i_y_in}, radius));
            if (gap > 0) begin
                gap     <= gap - 1;
                i_start <= 1'b0;
            end else if (vec_q.size() > 0 && !hold_off) begin
                i_x_in  <= vec_q[0].x;
                i_y_in  <= vec_q[0].y;
                void'(vec_q.pop_front());
                i_start <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    gap <= $urandom_range(1, 9);
            end else begin
                i_start <= 1'b0;
            end
        end
        if (i_cfg_valid && o_cfg_ready) begin
            radius      <= i_cfg_data;
            i_cfg_valid <= 1'b0;
        end else if (cfg_pending && !i_cfg_valid) begin
            i_cfg_data  <= cfg_req;
            i_cfg_valid <= 1'b1;
        end
    end

    // monitor: compare each strobed word with the oldest prediction
    always @(posedge i_clk) begin
        t_lim want;
        logic bad;
        bad = 1'b0;
        if (i_rst_n && o_valid) begin
            if (limited_q.size() == 0) begin
                $error("unexpected result x=%0d y=%0d", o_x_out, o_y_out);
                bad = 1'b1;
            end else begin
                want = limited_q.pop_front();
                if (o_x_out !== want.x) begin
                    $error("x_out expected %0d actual %0d", want.x, o_x_out);
                    bad = 1'b1;
                end
                if (o_y_out !== want.y) begin
                    $error("y_out expected %0d actual %0d", want.y, o_y_out);
                    bad = 1'b1;
                end
                if (o_was_limited !== want.limited) begin
                    $error("was_limited expected %0b actual %0b", want.limited,
                           o_was_limited);
                    bad = 1'b1;
                end
            end
        end
        if (bad)
            fails <= fails + 1;
    end

    // limit guard
    always @(posedge i_clk) begin
        if (cycle > MAX_CYCLE) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_vec(input logic [CW-1:0] x, input logic [CW-1:0] y);
        vec_q.push_back('{x, y});
    endtask

    // wait for every word to drain, then write a new limit
    task automatic settle_and_set(input logic [LW-1:0] lim);
        wait (vec_q.size() == 0 && !i_start && limited_q.size() == 0);
        repeat (LATENCY + 2) @(posedge i_clk);
        cfg_req     = lim;
        cfg_pending = 1'b1;
        @(posedge i_clk);
        wait (i_cfg_valid);
        cfg_pending = 1'b0;
        wait (!i_cfg_valid);
        @(posedge i_clk);
    endtask

    task automatic add_random(input int n);
        int k;
        int r;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 3);
            if (r == 0)
                add_vec(CW'($urandom_range(0, 16'hffff)), CW'($urandom_range(0, 16'hffff)));
            else if (r == 1)
                add_vec(CW'($urandom_range(0, 255) - 128), CW'($urandom_range(0, 255) - 128));
            else if (r == 2)
                add_vec(CW'(16'h8000 | $urandom_range(0, 3)), CW'($urandom_range(0, 16'hffff)));
            else
                add_vec(CW'($urandom_range(0, 16'h7fff)), CW'(16'h7fff - $urandom_range(0, 7)));
        end
    endtask

    initial begin
        logic [LW-1:0] lims[6];
        int ph;
        lims = '{15'd0, 15'd32767, 15'd1, 15'd16384, 15'd23170, 15'd100};
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_x_in      = '0;
        i_y_in      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        radius      = vml_pkg::LIMIT_RESET;
        cfg_pending = 1'b0;
        hold_off    = 1'b0;
        calm        = 1'b0;
        fails       = 0;
        cycle       = 0;
        cfg_req     = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero vector, most negative component
        add_vec(16'h0000, 16'h0000);
        add_vec(16'h8000, 16'h0000);
        add_vec(16'h0000, 16'h8000);
        add_vec(16'h8000, 16'h8000);
        add_vec(16'h7fff, 16'h7fff);
        add_vec(16'h7fff, 16'h0000);
        add_vec(16'h8001, 16'h7fff);
        add_vec(16'h0001, 16'hffff);
        add_vec(16'h5555, 16'haaaa);
        add_vec(16'h4000, 16'h4000);
        for (ph = 0; ph < 6; ph++) begin
            settle_and_set(lims[ph]);
            add_vec(16'h0000, 16'h0000);
            add_vec(16'h8000, 16'h0000);
            add_vec(16'h7fff, 16'h8000);
            add_vec(16'h0001, 16'h0000);
            add_random(60);
            // pause until every expected word has come
            if (ph == 2) begin
                wait (vec_q.size() < 30);
                hold_off = 1'b1;
                wait (limited_q.size() == 0 && !i_start);
                hold_off = 1'b0;
            end
        end
        for (ph = 0; ph < 6; ph++) begin
            settle_and_set(LW'($urandom_range(0, 32767)));
            add_random(120);
        end
        settle_and_set(lims[1]);
        calm = 1'b1;
        add_random(150);

        wait (vec_q.size() == 0 && !i_start && limited_q.size() == 0);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (fails == 0 && limited_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> vector_magnitude_limiter.f
rtl/vml_pkg.sv
rtl/vml_sqrt_cell.sv
rtl/vml_div_cell.sv
rtl/vector_magnitude_limiter.sv
dv/vector_magnitude_limiter_tb.sv
